// ===== rtl/multivalue_field_extract_defines.svh =====
// ---------------------------------------------------------------------------
// Multivalue field extract assertion macros
// Shared concurrent assertion forms for the extract datapath.
// ---------------------------------------------------------------------------
`ifndef MULTIVALUE_FIELD_EXTRACT_DEFINES_SVH
`define MULTIVALUE_FIELD_EXTRACT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mvfe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MVFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mvfe: next-cycle check failed");

`endif

// ===== rtl/mvfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Multivalue field extract package
// Shared widths, register indexes and structures of the extract block.
// ---------------------------------------------------------------------------
package mvfe_pkg;

	localparam int unsigned IdxW   = 16;
	localparam int unsigned MarkW  = 8;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CfgIdW = 3;

	typedef logic [IdxW-1:0]   idx_t;
	typedef logic [MarkW-1:0]  mark_t;
	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [CfgIdW-1:0] cfg_id_t;

	localparam cfg_id_t REG_ATTRIBUTE_INDEX = 3'd0;
	localparam cfg_id_t REG_VALUE_INDEX     = 3'd1;
	localparam cfg_id_t REG_SUBVALUE_INDEX  = 3'd2;
	localparam cfg_id_t REG_ATTRIBUTE_MARK  = 3'd3;
	localparam cfg_id_t REG_VALUE_MARK      = 3'd4;
	localparam cfg_id_t REG_SUBVALUE_MARK   = 3'd5;

	localparam mark_t ATTRIBUTE_MARK_RST = 8'd254;
	localparam mark_t VALUE_MARK_RST     = 8'd253;
	localparam mark_t SUBVALUE_MARK_RST  = 8'd252;

	typedef struct packed {
		idx_t  attribute_index;
		idx_t  value_index;
		idx_t  subvalue_index;
		mark_t attribute_mark;
		mark_t value_mark;
		mark_t subvalue_mark;
	} cfg_t;

	typedef struct packed {
		idx_t attribute_count;
		idx_t value_count;
		idx_t subvalue_count;
	} counts_t;

	localparam counts_t COUNTS_ZERO = '0;

endpackage

// ===== rtl/mvfe_select.sv =====
// ---------------------------------------------------------------------------
// Multivalue field extract selection logic
// Classifies one byte, decides whether it is kept and computes next counts.
// ---------------------------------------------------------------------------
module mvfe_select (
	input  mvfe_pkg::cfg_t    cfg,
	input  mvfe_pkg::counts_t counts,
	input  mvfe_pkg::byte_t   data,
	input  logic              last,
	output logic              keep,
	output mvfe_pkg::counts_t counts_next
);
	import mvfe_pkg::*;

	logic use_a, use_v, use_s;
	logic is_a, is_v, is_s;
	logic in_a, in_v, in_s;

	function automatic idx_t sat_inc(input idx_t c);
		sat_inc = (c == '1) ? c : c + idx_t'(1);
	endfunction

	always_comb begin
		use_a = cfg.attribute_index != '0;
		use_v = cfg.value_index != '0;
		use_s = (cfg.subvalue_index != '0) && (use_v || !use_a);

		is_a = data == cfg.attribute_mark;
		is_v = !is_a && (data == cfg.value_mark);
		is_s = !is_a && !is_v && (data == cfg.subvalue_mark);

		in_a = !use_a || (counts.attribute_count == cfg.attribute_index - idx_t'(1));
		in_v = !use_v || (counts.value_count == cfg.value_index - idx_t'(1));
		in_s = !use_s || (counts.subvalue_count == cfg.subvalue_index - idx_t'(1));

		keep = (use_a || use_v || use_s) && in_a && in_v && in_s
			&& !((is_a && use_a) || (is_v && use_v) || (is_s && use_s));
	end

	always_comb begin
		counts_next = counts;
		if (is_a) begin
			counts_next.attribute_count = sat_inc(counts.attribute_count);
			if (use_a) begin
				counts_next.value_count    = '0;
				counts_next.subvalue_count = '0;
			end
		end else if (is_v) begin
			counts_next.value_count = sat_inc(counts.value_count);
			if (use_v) begin
				counts_next.subvalue_count = '0;
			end
		end else if (is_s) begin
			counts_next.subvalue_count = sat_inc(counts.subvalue_count);
		end
		if (last) begin
			counts_next = COUNTS_ZERO;
		end
	end

endmodule

// ===== rtl/multivalue_field_extract.sv =====
// ---------------------------------------------------------------------------
// Multivalue field extract
// Flags the bytes of a multivalue record byte stream in one attribute/value/subvalue.
// ---------------------------------------------------------------------------
// Usage: record bytes enter on the s_ channel, one byte per beat, with s_tlast
// on the final byte of a record. Every input beat yields exactly one output
// beat on the m_ channel carrying the same byte, a keep flag in m_tuser and
// the record end in m_tlast. Selection indexes and mark codes are written
// through cfg_we/cfg_index/cfg_data while the stream is idle.
// An input beat reaches the output through one input register
// and one result register. Throughput is one beat per cycle while the receiver
// does not stall; the mark counters are updated between the two registers.
// Reset clears both stages, the mark counters and loads the default
// configuration (indexes zero, marks 254, 253 and 252). When the receiver
// stalls, the result register holds its beat and the input register keeps
// one more beat; s_tready drops only when both are full and m_tready is low.
// ---------------------------------------------------------------------------
`include "multivalue_field_extract_defines.svh"

module multivalue_field_extract (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  mvfe_pkg::byte_t         s_tdata,   // [7:0] in_byte
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output mvfe_pkg::byte_t         m_tdata,   // [7:0] out_byte
	output logic                    m_tuser,   // [0] keep
	output logic                    m_tlast,
	input  logic                    cfg_we,
	input  mvfe_pkg::cfg_id_t       cfg_index,
	input  mvfe_pkg::idx_t          cfg_data
);
	import mvfe_pkg::*;

	cfg_t    cfg_q;
	counts_t counts_q;
	counts_t counts_next;

	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;

	logic  valid_s2;
	byte_t data_s2;
	logic  keep_s2;
	logic  last_s2;

	logic  keep_c;
	logic  free_s2;
	logic  adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attribute_index <= '0;
			cfg_q.value_index     <= '0;
			cfg_q.subvalue_index  <= '0;
			cfg_q.attribute_mark  <= ATTRIBUTE_MARK_RST;
			cfg_q.value_mark      <= VALUE_MARK_RST;
			cfg_q.subvalue_mark   <= SUBVALUE_MARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTRIBUTE_INDEX: cfg_q.attribute_index <= cfg_data;
				REG_VALUE_INDEX:     cfg_q.value_index     <= cfg_data;
				REG_SUBVALUE_INDEX:  cfg_q.subvalue_index  <= cfg_data;
				REG_ATTRIBUTE_MARK:  cfg_q.attribute_mark  <= cfg_data[MarkW-1:0];
				REG_VALUE_MARK:      cfg_q.value_mark      <= cfg_data[MarkW-1:0];
				REG_SUBVALUE_MARK:   cfg_q.subvalue_mark   <= cfg_data[MarkW-1:0];
				default: ;
			endcase
		end
	end

	assign free_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && free_s2;
	assign s_tready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mvfe_select u_select (
		.cfg         (cfg_q),
		.counts      (counts_q),
		.data        (data_s1),
		.last        (last_s1),
		.keep        (keep_c),
		.counts_next (counts_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= COUNTS_ZERO;
		end else if (adv_s1) begin
			counts_q <= counts_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= data_s1;
			keep_s2 <= keep_c;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = keep_s2;
	assign m_tlast  = last_s2;

	`MVFE_ASSERT_NEXT(a_counts_clear_at_end, clk, arst_n, adv_s1 && last_s1,
		counts_q == COUNTS_ZERO)
	`MVFE_ASSERT_NEXT(a_no_keep_without_index, clk, arst_n,
		adv_s1 && cfg_q.attribute_index == '0 && cfg_q.value_index == '0
		&& cfg_q.subvalue_index == '0, !m_tuser)
	`MVFE_ASSERT_SAME(a_hold_when_stalled, clk, arst_n, m_tvalid && !m_tready,
		!adv_s1)

endmodule

// ===== bench/multivalue_field_extract_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Multivalue field extract testbench
// Streams multivalue records through the extractor under several selection
// and mark settings and under varied source and sink backpressure. Each
// output beat is compared with a local model of the mark counters and the
// keep decision.
// ---------------------------------------------------------------------------
module multivalue_field_extract_test;

	import mvfe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1500000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 6;
	localparam int          PRINT_LIMIT  = 40;

	typedef struct packed {
		byte_t out_byte;
		logic  keep;
		logic  end_of_result;
	} extract_beat_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    s_tvalid  = 1'b0;
	logic    s_tready;
	byte_t   s_tdata   = '0;
	logic    s_tlast   = 1'b0;
	logic    m_tvalid;
	logic    m_tready  = 1'b0;
	byte_t   m_tdata;
	logic    m_tuser;
	logic    m_tlast;
	logic    cfg_we    = 1'b0;
	cfg_id_t cfg_index = REG_ATTRIBUTE_INDEX;
	idx_t    cfg_data  = '0;

	cfg_t model_cfg = '{16'd0, 16'd0, 16'd0,
		ATTRIBUTE_MARK_RST, VALUE_MARK_RST, SUBVALUE_MARK_RST};
	counts_t model_counts = COUNTS_ZERO;
	extract_beat_t expected_extracts[$];

	int          error_count    = 0;
	int unsigned cycle_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_req       = 0;
	int          hold_ack       = 0;
	int          hold_left      = 0;

	multivalue_field_extract i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] in_byte
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] out_byte
		.m_tuser   (m_tuser),   // [0] keep
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// A long hold-off is requested by bumping hold_req; it lets the block fill up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic idx_t sat_inc(input idx_t c);
		return (c == '1) ? c : idx_t'(c + 1'b1);
	endfunction

	function automatic void predict_extract(input byte_t b, input logic last);
		logic use_a, use_v, use_s, is_a, is_v, is_s, in_a, in_v, in_s;
		extract_beat_t beat;
		use_a = model_cfg.attribute_index != '0;
		use_v = model_cfg.value_index != '0;
		use_s = model_cfg.subvalue_index != '0 && (use_v || !use_a);
		is_a = b == model_cfg.attribute_mark;
		is_v = !is_a && b == model_cfg.value_mark;
		is_s = !is_a && !is_v && b == model_cfg.subvalue_mark;
		in_a = !use_a ||
			model_counts.attribute_count == idx_t'(model_cfg.attribute_index - 1'b1);
		in_v = !use_v ||
			model_counts.value_count == idx_t'(model_cfg.value_index - 1'b1);
		in_s = !use_s ||
			model_counts.subvalue_count == idx_t'(model_cfg.subvalue_index - 1'b1);
		beat.out_byte = b;
		beat.keep = (use_a || use_v || use_s) && in_a && in_v && in_s &&
			!(is_a && use_a) && !(is_v && use_v) && !(is_s && use_s);
		beat.end_of_result = last;
		if (is_a) begin
			model_counts.attribute_count = sat_inc(model_counts.attribute_count);
			if (use_a) begin
				model_counts.value_count = '0;
				model_counts.subvalue_count = '0;
			end
		end else if (is_v) begin
			model_counts.value_count = sat_inc(model_counts.value_count);
			if (use_v) begin
				model_counts.subvalue_count = '0;
			end
		end else if (is_s) begin
			model_counts.subvalue_count = sat_inc(model_counts.subvalue_count);
		end
		if (last) begin
			model_counts = COUNTS_ZERO;
		end
		expected_extracts.push_back(beat);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < PRINT_LIMIT) begin
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		end
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		extract_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_extracts.size() == 0) begin
				report_mismatch("unexpected beat, out_byte", int'(m_tdata), 0);
			end else begin
				want = expected_extracts.pop_front();
				if (m_tdata !== want.out_byte) begin
					report_mismatch("out_byte", int'(m_tdata), int'(want.out_byte));
				end
				if (m_tuser !== want.keep) begin
					report_mismatch("keep", int'(m_tuser), int'(want.keep));
				end
				if (m_tlast !== want.end_of_result) begin
					report_mismatch("end_of_result", int'(m_tlast),
						int'(want.end_of_result));
				end
			end
		end
	end

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	task automatic send_record_byte(input byte_t b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_extract(b, last);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_extracts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_id_t id, input idx_t data);
		cfg_we <= 1'b1;
		cfg_index <= id;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_config(input cfg_t c);
		wait_drained();
		write_reg(REG_ATTRIBUTE_INDEX, c.attribute_index);
		write_reg(REG_VALUE_INDEX, c.value_index);
		write_reg(REG_SUBVALUE_INDEX, c.subvalue_index);
		write_reg(REG_ATTRIBUTE_MARK, idx_t'(c.attribute_mark));
		write_reg(REG_VALUE_MARK, idx_t'(c.value_mark));
		write_reg(REG_SUBVALUE_MARK, idx_t'(c.subvalue_mark));
		cfg_we <= 1'b0;
		@(posedge clk);
		model_cfg = c;
	endtask

	function automatic idx_t pick_index();
		return ($urandom_range(7) == 0) ? idx_t'(16'hFFFF) : idx_t'($urandom_range(3));
	endfunction

	function automatic cfg_t pick_config(input int kind);
		cfg_t c;
		c.attribute_index = pick_index();
		c.value_index = pick_index();
		c.subvalue_index = pick_index();
		c.attribute_mark = ATTRIBUTE_MARK_RST;
		c.value_mark = VALUE_MARK_RST;
		c.subvalue_mark = SUBVALUE_MARK_RST;
		if ($urandom_range(1) == 0) begin
			c.attribute_mark = mark_t'($urandom_range(255));
			c.value_mark = mark_t'($urandom_range(255));
			c.subvalue_mark = mark_t'($urandom_range(255));
		end
		if (kind == 1) begin
			c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'hFF};
		end else if (kind == 2) begin
			c.attribute_index = '0;
			c.value_index = '0;
			c.subvalue_index = '0;
		end
		return c;
	endfunction

	function automatic byte_t pick_byte();
		int r;
		r = $urandom_range(9);
		if (r < 2) begin
			return model_cfg.attribute_mark;
		end else if (r < 4) begin
			return model_cfg.value_mark;
		end else if (r < 6) begin
			return model_cfg.subvalue_mark;
		end
		return byte_t'($urandom_range(255));
	endfunction

	task automatic send_record(input int len, input bit noise);
		int i;
		for (i = 0; i < len; i++) begin
			send_record_byte(noise ? byte_t'($urandom_range(255)) : pick_byte(),
				i == len - 1);
		end
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		// With every index zero nothing is kept.
		send_record_byte(8'h00, 1'b0);
		send_record_byte(ATTRIBUTE_MARK_RST, 1'b0);
		send_record_byte(8'hFF, 1'b1);
		// Subvalue without a value under a selected attribute keeps the whole attribute.
		write_config('{16'd2, 16'd0, 16'd3,
			ATTRIBUTE_MARK_RST, VALUE_MARK_RST, SUBVALUE_MARK_RST});
		send_record_byte(8'h41, 1'b0);
		send_record_byte(ATTRIBUTE_MARK_RST, 1'b0);
		send_record_byte(8'h42, 1'b0);
		send_record_byte(VALUE_MARK_RST, 1'b0);
		send_record_byte(8'h43, 1'b0);
		send_record_byte(SUBVALUE_MARK_RST, 1'b0);
		send_record_byte(8'h44, 1'b0);
		send_record_byte(ATTRIBUTE_MARK_RST, 1'b0);
		send_record_byte(8'h45, 1'b1);
		// Equal attribute and value codes classify as attribute marks.
		write_config('{16'd0, 16'd1, 16'd0, 8'h00, 8'h00, 8'hFF});
		send_record_byte(8'h10, 1'b0);
		send_record_byte(8'h00, 1'b0);
		send_record_byte(8'h11, 1'b0);
		send_record_byte(8'hFF, 1'b0);
		send_record_byte(8'h12, 1'b1);
		// An attribute index past the end of the record keeps nothing.
		write_config('{16'd5, 16'd1, 16'd1,
			ATTRIBUTE_MARK_RST, VALUE_MARK_RST, SUBVALUE_MARK_RST});
		send_record_byte(8'h61, 1'b0);
		send_record_byte(ATTRIBUTE_MARK_RST, 1'b0);
		send_record_byte(8'h62, 1'b1);
	endtask

	task automatic test_backpressure();
		int n;
		set_idling(0, 0);
		write_config(pick_config(0));
		hold_req <= hold_req + 1;
		for (n = 0; n < 60; n++) begin
			if (n == 30) begin
				wait_drained();
			end
			send_record_byte(pick_byte(), n % 10 == 9);
		end
	endtask

	task automatic test_random_records();
		int p;
		int n;
		int len;
		for (p = 0; p < 8; p++) begin
			write_config(pick_config(p));
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(73, 0);
				2: set_idling(0, 73);
				default: set_idling(9, 9);
			endcase
			n = 0;
			while (n < 75) begin
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
				send_record(len, $urandom_range(99) < 15);
				n += len;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_records();
		wait_drained();
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== multivalue_field_extract.f =====
+incdir+rtl
rtl/mvfe_pkg.sv
rtl/mvfe_select.sv
rtl/multivalue_field_extract.sv
bench/multivalue_field_extract_test.sv
